### rtl/mwa_pkg.sv
// shared types and constants for the minimum covering window block
// no dependencies; imported by mwa_ctrl, mwa_dp and min_window_all_terms_unit
`timescale 1ns / 1ps
`default_nettype none

package mwa_pkg;

    // field widths fixed by the stream format
    localparam int unsigned TERM_W = 5;
    localparam int unsigned POS_W  = 32;
    localparam int unsigned WIN_W  = 32;
    localparam int unsigned QLEN_W = 6;
    // term counts up to 64 (query length 6 bits, at most 64 lanes)
    localparam int unsigned NUM_W  = 7;

    localparam logic CMD_HIT     = 1'b0;
    localparam logic CMD_NEW_DOC = 1'b1;

    typedef enum logic [2:0] {
        S_IDLE,
        S_EXEC,
        S_CMP,
        S_SCAN,
        S_DRAIN,
        S_APPLY,
        S_DONE
    } t_state;

    // controller to datapath
    typedef struct packed {
        logic latch;       // take the input beat
        logic clear;       // new document
        logic mark_write;  // first hit of a term: write position, set seen bit
        logic write_pos;   // update latest position of the term
        logic scan_start;  // reset the min accumulator and scan counter
        logic scan_step;   // issue one read of the scan
        logic apply;       // commit the scan result to the window state
        logic load_out;    // load the result register
    } t_dp_cmd;

    // datapath to controller
    typedef struct packed {
        logic is_new_doc;
        logic in_range;
        logic seen_t;
        logic hit_start;
        logic scan_last;
        logic out_free;
    } t_dp_stat;

endpackage

`default_nettype wire

### rtl/mwa_ctrl.sv
// sequencer for the minimum covering window block
// depends on mwa_pkg; drives mwa_dp through t_dp_cmd and reads t_dp_stat
`timescale 1ns / 1ps
`default_nettype none

module mwa_ctrl (
    input  wire                 i_clk,
    input  wire                 i_rst_n,
    input  wire                 i_in_valid,
    output logic                o_in_ready,
    input  mwa_pkg::t_dp_stat   i_stat,
    output mwa_pkg::t_dp_cmd    o_cmd
);
    import mwa_pkg::*;

    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    n_state = S_EXEC;
                end
            end
            S_EXEC: begin
                if (i_stat.is_new_doc || !i_stat.in_range) begin
                    n_state = S_DONE;
                end else if (!i_stat.seen_t) begin
                    n_state = S_SCAN;
                end else begin
                    n_state = S_CMP;
                end
            end
            S_CMP: begin
                n_state = i_stat.hit_start ? S_SCAN : S_DONE;
            end
            S_SCAN: begin
                if (i_stat.scan_last) begin
                    n_state = S_DRAIN;
                end
            end
            S_DRAIN: n_state = S_APPLY;
            S_APPLY: n_state = S_DONE;
            S_DONE: begin
                if (i_stat.out_free) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_comb begin
        o_in_ready = 1'b0;
        o_cmd      = '0;
        case (r_state)
            S_IDLE: begin
                o_in_ready  = 1'b1;
                o_cmd.latch = i_in_valid;
            end
            S_EXEC: begin
                if (i_stat.is_new_doc) begin
                    o_cmd.clear = 1'b1;
                end else if (i_stat.in_range && !i_stat.seen_t) begin
                    o_cmd.mark_write = 1'b1;
                    o_cmd.scan_start = 1'b1;
                end
            end
            S_CMP: begin
                o_cmd.write_pos  = 1'b1;
                o_cmd.scan_start = i_stat.hit_start;
            end
            S_SCAN:  o_cmd.scan_step = 1'b1;
            S_DRAIN: o_cmd           = '0;
            S_APPLY: o_cmd.apply     = 1'b1;
            S_DONE:  o_cmd.load_out  = i_stat.out_free;
            default: o_cmd           = '0;
        endcase
    end

endmodule

`default_nettype wire

### rtl/mwa_dp.sv
// datapath: position memory, seen bits, window state, min scan and result register
// depends on mwa_pkg; sequenced by mwa_ctrl
`timescale 1ns / 1ps
`default_nettype none

module mwa_dp #(
    parameter int unsigned MAX_TERMS     = 32,
    parameter int unsigned POSITION_BITS = 32
) (
    input  wire                          i_clk,
    input  wire                          i_rst_n,
    input  wire                          i_cfg_valid,
    input  wire  [mwa_pkg::QLEN_W-1:0]   i_cfg_data,
    input  wire                          i_cmd_bit,
    input  wire  [mwa_pkg::TERM_W-1:0]   i_term_index,
    input  wire  [mwa_pkg::POS_W-1:0]    i_position,
    input  mwa_pkg::t_dp_cmd             i_cmd,
    output mwa_pkg::t_dp_stat            o_stat,
    input  wire                          i_out_ready,
    output logic                         o_out_valid,
    output logic                         o_all_covered,
    output logic [mwa_pkg::POS_W-1:0]    o_window_start,
    output logic [mwa_pkg::WIN_W-1:0]    o_best_window,
    output logic [mwa_pkg::POS_W-1:0]    o_first_full_position
);
    import mwa_pkg::*;

    localparam int unsigned IW = (MAX_TERMS > 1) ? $clog2(MAX_TERMS) : 1;
    localparam int unsigned PB = POSITION_BITS;

    // latched item
    logic              r_cmd_bit;
    logic [TERM_W-1:0] r_t;
    logic [PB-1:0]     r_pos;

    logic [QLEN_W-1:0]    r_ql;
    logic [MAX_TERMS-1:0] r_seen;
    logic                 r_covered;
    logic [PB-1:0]        r_start;
    logic [WIN_W-1:0]     r_best;
    logic [PB-1:0]        r_first;

    // latest positions, undefined until written
    logic [PB-1:0] r_mem [MAX_TERMS];
    logic [PB-1:0] r_rd_data;

    // scan
    logic [IW-1:0] r_idx;
    logic          r_pend;
    logic [IW-1:0] r_pend_idx;
    logic [PB-1:0] r_low;
    logic          r_have;
    logic          r_all;

    logic             r_out_valid;
    logic             r_out_cov;
    logic [PB-1:0]    r_out_start;
    logic [WIN_W-1:0] r_out_best;
    logic [PB-1:0]    r_out_first;

    logic [NUM_W-1:0] terms_used;
    logic [NUM_W-1:0] term_ext;
    logic [IW-1:0]    term_addr;
    logic [IW-1:0]    rd_addr;
    logic             out_free;
    logic             do_update;
    logic [PB:0]      len_full;
    logic [WIN_W-1:0] len_sat;
    logic [NUM_W-1:0] idx_ext;

    always_comb begin
        if ({1'b0, r_ql} > NUM_W'(MAX_TERMS)) begin
            terms_used = NUM_W'(MAX_TERMS);
        end else begin
            terms_used = {1'b0, r_ql};
        end
    end

    assign term_ext  = {{(NUM_W - TERM_W){1'b0}}, r_t};
    assign term_addr = term_ext[IW-1:0];
    assign idx_ext   = NUM_W'(r_idx);
    assign rd_addr   = i_cmd.scan_step ? r_idx : term_addr;
    assign out_free  = !r_out_valid || i_out_ready;

    assign o_stat.is_new_doc = (r_cmd_bit == CMD_NEW_DOC);
    assign o_stat.in_range   = (term_ext < terms_used);
    assign o_stat.seen_t     = r_seen[term_addr];
    assign o_stat.hit_start  = r_covered && (r_rd_data == r_start);
    assign o_stat.scan_last  = (idx_ext == terms_used - NUM_W'(1));
    assign o_stat.out_free   = out_free;

    // window length, saturated to the result width
    always_comb begin
        if (r_pos >= r_low) begin
            len_full = {1'b0, r_pos} - {1'b0, r_low} + (PB + 1)'(1);
        end else begin
            len_full = (PB + 1)'(1);
        end
        if ((WIN_W + 1)'(len_full) > (WIN_W + 1)'({WIN_W{1'b1}})) begin
            len_sat = '1;
        end else begin
            len_sat = WIN_W'(len_full);
        end
    end

    assign do_update = r_all && r_have && !(r_covered && (r_low <= r_start));

    // memory
    always_ff @(posedge i_clk) begin
        if (i_cmd.mark_write || i_cmd.write_pos) begin
            r_mem[term_addr] <= r_pos;
        end
        r_rd_data <= r_mem[rd_addr];
    end

    // item and result payload
    always_ff @(posedge i_clk) begin
        if (i_cmd.latch) begin
            r_cmd_bit <= i_cmd_bit;
            r_t       <= i_term_index;
            r_pos     <= i_position[PB-1:0];
        end
        if (i_cmd.load_out) begin
            r_out_cov   <= r_covered;
            r_out_start <= r_covered ? r_start : '0;
            r_out_best  <= r_best;
            r_out_first <= r_covered ? r_first : '0;
        end
        if (i_cmd.scan_step) begin
            r_pend_idx <= r_idx;
        end
    end

    // min accumulator over the scanned positions
    always_ff @(posedge i_clk) begin
        if (i_cmd.scan_start) begin
            r_have <= 1'b0;
            r_all  <= 1'b1;
        end else if (r_pend) begin
            if (r_seen[r_pend_idx]) begin
                if (!r_have || (r_rd_data < r_low)) begin
                    r_low <= r_rd_data;
                end
                r_have <= 1'b1;
            end else begin
                r_all <= 1'b0;
            end
        end
    end

    // control and document state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ql        <= QLEN_W'(1);
            r_seen      <= '0;
            r_covered   <= 1'b0;
            r_start     <= '0;
            r_best      <= '0;
            r_first     <= '0;
            r_idx       <= '0;
            r_pend      <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cfg_valid) begin
                r_ql <= i_cfg_data;
            end
            r_pend <= i_cmd.scan_step;
            if (i_cmd.scan_start) begin
                r_idx <= '0;
            end else if (i_cmd.scan_step) begin
                r_idx <= r_idx + IW'(1);
            end
            if (i_cmd.clear) begin
                r_seen    <= '0;
                r_covered <= 1'b0;
                r_start   <= '0;
                r_best    <= '0;
                r_first   <= '0;
            end
            if (i_cmd.mark_write) begin
                r_seen[term_addr] <= 1'b1;
            end
            if (i_cmd.apply && do_update) begin
                if (!r_covered) begin
                    r_covered <= 1'b1;
                    r_first   <= r_pos;
                end
                r_start <= r_low;
                if ((r_best == '0) || (len_sat < r_best)) begin
                    r_best <= len_sat;
                end
            end
            if (i_cmd.load_out) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    assign o_out_valid           = r_out_valid;
    assign o_all_covered         = r_out_cov;
    assign o_window_start        = POS_W'(r_out_start);
    assign o_best_window         = r_out_best;
    assign o_first_full_position = POS_W'(r_out_first);

endmodule

`default_nettype wire

### rtl/min_window_all_terms_unit.sv
// a new-document beat or an ignored hit goes from EXEC straight to DONE; a hit that needs
// no rescan passes through CMP; the first hit of a term rescans the n terms in use (SCAN,
// DRAIN, APPLY), and a hit on the term at the window start passes CMP and then that rescan;
// one item in flight at a time, so a new item is taken only once the result is loaded;
// the rescan reads one stored position per cycle from the single-port position memory
// synchronous active-low reset: empty document, query length 1, no result pending
`timescale 1ns / 1ps
`default_nettype none

module min_window_all_terms_unit #(
    parameter int unsigned MAX_TERMS     = 32,
    parameter int unsigned POSITION_BITS = 32
) (
    input  wire         i_clk,
    input  wire         i_rst_n,
    // configuration: query_length
    input  wire         i_cfg_valid,
    output logic        o_cfg_ready,
    input  wire  [5:0]  i_cfg_data,
    input  wire         s_axis_tvalid,
    output logic        s_axis_tready,
    input  wire  [39:0] s_axis_tdata,   // term_index[4:0], position[36:5], zero pad
    input  wire  [0:0]  s_axis_tuser,   // cmd
    output logic        m_axis_tvalid,
    input  wire         m_axis_tready,
    output logic [95:0] m_axis_tdata,   // window_start[31:0], best_window[63:32],
                                        // first_full_position[95:64]
    output logic [0:0]  m_axis_tuser    // all_covered
);
    import mwa_pkg::*;

    t_dp_cmd  dp_cmd;
    t_dp_stat dp_stat;

    logic              all_covered;
    logic [POS_W-1:0]  window_start;
    logic [WIN_W-1:0]  best_window;
    logic [POS_W-1:0]  first_full_position;

    assign o_cfg_ready = 1'b1;

    mwa_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (s_axis_tvalid),
        .o_in_ready (s_axis_tready),
        .i_stat     (dp_stat),
        .o_cmd      (dp_cmd)
    );

    mwa_dp #(
        .MAX_TERMS     (MAX_TERMS),
        .POSITION_BITS (POSITION_BITS)
    ) u_dp (
        .i_clk                 (i_clk),
        .i_rst_n               (i_rst_n),
        .i_cfg_valid           (i_cfg_valid),
        .i_cfg_data            (i_cfg_data),
        .i_cmd_bit             (s_axis_tuser[0]),
        .i_term_index          (s_axis_tdata[4:0]),
        .i_position            (s_axis_tdata[36:5]),
        .i_cmd                 (dp_cmd),
        .o_stat                (dp_stat),
        .i_out_ready           (m_axis_tready),
        .o_out_valid           (m_axis_tvalid),
        .o_all_covered         (all_covered),
        .o_window_start        (window_start),
        .o_best_window         (best_window),
        .o_first_full_position (first_full_position)
    );

    assign m_axis_tdata = {first_full_position, best_window, window_start};
    assign m_axis_tuser = all_covered;

endmodule

`default_nettype wire

### tb/tb_min_window_all_terms_unit.sv
// self-checking testbench for min_window_all_terms_unit: warm-up hits, directed rows, then random documents
// depends on rtl/mwa_pkg.sv and rtl/min_window_all_terms_unit.sv; results checked by an
// in-bench window predictor, with random sender bursts and receiver stalls
`timescale 1ns / 1ps

module tb_min_window_all_terms_unit;
    import mwa_pkg::*;

    localparam int unsigned TERMS      = 32;
    localparam int unsigned RAND_ITEMS = 1400;
    localparam int unsigned IDLE_LIMIT = 3000;
    localparam int unsigned END_PAUSE  = 48;
    localparam logic [31:0] POS_TOP    = 32'hFFFF_FFFE;

    typedef struct packed {
        logic        covered;
        logic [31:0] win_start;
        logic [31:0] best_len;
        logic [31:0] first_full;
    } t_cover_result;

    localparam t_cover_result NO_COVER = '0;

    typedef struct {
        logic [5:0]        qlen;
        logic              cmd;
        logic [TERM_W-1:0] term;
        logic [31:0]       pos;
        bit                typed;
        t_cover_result     want;
    } t_dir_row;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_cfg_valid = 1'b0;
    logic [5:0]  i_cfg_data = '0;
    logic        s_axis_tvalid = 1'b0;
    logic [39:0] s_axis_tdata = '0;
    logic [0:0]  s_axis_tuser = '0;
    logic        m_axis_tready = 1'b0;
    wire         o_cfg_ready;
    wire         s_axis_tready;
    wire         m_axis_tvalid;
    wire  [95:0] m_axis_tdata;
    wire  [0:0]  m_axis_tuser;

    min_window_all_terms_unit uut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_valid   (i_cfg_valid),
        .o_cfg_ready   (o_cfg_ready),
        .i_cfg_data    (i_cfg_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // predictor state
    logic [5:0]       cur_qlen = 6'd1;
    logic [31:0]      term_pos [TERMS];
    logic [TERMS-1:0] term_hit_map = '0;
    logic             doc_covered = 1'b0;
    logic [31:0]      win_start = '0;
    logic [31:0]      best_len = '0;
    logic [31:0]      first_full = '0;

    t_cover_result window_q [$];
    int unsigned   err_cnt = 0;
    int unsigned   beat_cnt = 0;
    int unsigned   counted = 0;
    int unsigned   burst_left = 0;

    // stimulus generator's view of the document
    longint        gen_last [TERMS];
    bit            gen_seen [TERMS];
    longint        cursor;

    function automatic t_cover_result predict_window(logic cmd, logic [TERM_W-1:0] t,
                                                     logic [31:0] pos);
        int unsigned   n;
        bit            rescan;
        bit            have;
        bit            all_in;
        logic [31:0]   lo;
        longint        span;
        t_cover_result r;
        n = (cur_qlen > TERMS) ? TERMS : cur_qlen;
        rescan = 1'b0;
        if (cmd == CMD_NEW_DOC) begin
            term_hit_map = '0;
            doc_covered = 1'b0;
            win_start = '0;
            best_len = '0;
            first_full = '0;
        end else if (t < n) begin
            if (!term_hit_map[t]) begin
                term_hit_map[t] = 1'b1;
                rescan = 1'b1;
            end else if (doc_covered && term_pos[t] == win_start) begin
                rescan = 1'b1;
            end
            term_pos[t] = pos;
        end
        if (rescan) begin
            have = 1'b0;
            all_in = 1'b1;
            lo = '0;
            for (int i = 0; i < n; i++) begin
                if (term_hit_map[i]) begin
                    if (!have || term_pos[i] < lo) lo = term_pos[i];
                    have = 1'b1;
                end else begin
                    all_in = 1'b0;
                end
            end
            // start only ever moves forward once covered
            if (all_in && have && !(doc_covered && lo <= win_start)) begin
                if (!doc_covered) begin
                    doc_covered = 1'b1;
                    first_full = pos;
                end
                win_start = lo;
                span = (pos >= lo) ? (longint'(pos) - longint'(lo) + 1) : 1;
                if (span > 64'hFFFF_FFFF) span = 64'hFFFF_FFFF;
                if (best_len == 0 || span[31:0] < best_len) best_len = span[31:0];
            end
        end
        r.covered    = doc_covered;
        r.win_start  = doc_covered ? win_start : '0;
        r.best_len   = best_len;
        r.first_full = doc_covered ? first_full : '0;
        return r;
    endfunction

    task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
        $display("mismatch %s: got %h want %h (result beat %0d)", what, got, want, beat_cnt);
        err_cnt++;
    endtask

    // receiver: switches among always ready, a repeating 13-bit ready pattern and random ready
    int unsigned rx_cyc = 0;
    int unsigned rx_mode = 0;
    logic [12:0] rx_pattern = 13'h1;
    always @(posedge i_clk) begin
        rx_cyc <= rx_cyc + 1;
        if (rx_cyc % 250 == 0) begin
            rx_mode <= $urandom_range(0, 2);
            rx_pattern <= 13'($urandom) | 13'h1;
        end
        case (rx_mode)
            0: m_axis_tready <= 1'b1;
            1: m_axis_tready <= rx_pattern[rx_cyc % 13];
            default: m_axis_tready <= ($urandom_range(0, 3) != 0);
        endcase
    end

    // result checker, sampled at the falling edge where everything is settled
    always @(negedge i_clk) begin
        t_cover_result want;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            if (window_q.size() == 0) begin
                report_mismatch("beat with nothing expected", m_axis_tdata[31:0], '0);
            end else begin
                want = window_q.pop_front();
                if (m_axis_tuser[0] !== want.covered)
                    report_mismatch("all_covered", {31'b0, m_axis_tuser[0]},
                                    {31'b0, want.covered});
                if (m_axis_tdata[31:0] !== want.win_start)
                    report_mismatch("window_start", m_axis_tdata[31:0], want.win_start);
                if (m_axis_tdata[63:32] !== want.best_len)
                    report_mismatch("best_window", m_axis_tdata[63:32], want.best_len);
                if (m_axis_tdata[95:64] !== want.first_full)
                    report_mismatch("first_full_position", m_axis_tdata[95:64],
                                    want.first_full);
            end
            beat_cnt++;
        end
    end

    // watchdog on cycles with no beat on any channel
    int unsigned idle_cyc = 0;
    always @(negedge i_clk) begin
        if (!i_rst_n || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)
            || (i_cfg_valid && o_cfg_ready)) begin
            idle_cyc <= 0;
        end else if (idle_cyc >= IDLE_LIMIT) begin
            $display("watchdog: no beat for %0d cycles", IDLE_LIMIT);
            $display("tb_min_window_all_terms_unit NOT OK");
            $finish;
        end else begin
            idle_cyc <= idle_cyc + 1;
        end
    end

    // called at a rising edge, returns at the rising edge where the beat was taken
    task automatic send_beat(logic cmd, logic [TERM_W-1:0] t, logic [31:0] pos,
                             bit typed, t_cover_result want);
        int unsigned gap;
        t_cover_result pred;
        if (burst_left == 0) begin
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
            if (gap > 0) begin
                s_axis_tvalid <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
            burst_left = $urandom_range(1, 24);
        end
        burst_left--;
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {3'b0, pos, t};
        s_axis_tuser  <= cmd;
        @(negedge i_clk);
        while (!s_axis_tready) begin
            @(posedge i_clk);
            @(negedge i_clk);
        end
        @(posedge i_clk);
        pred = predict_window(cmd, t, pos);
        window_q.push_back(typed ? want : pred);
    endtask

    // hold the sender until every result is back, then write query_length
    task automatic settle_and_configure(logic [5:0] qlen);
        s_axis_tvalid <= 1'b0;
        burst_left = 0;
        do @(posedge i_clk); while (window_q.size() != 0);
        i_cfg_valid <= 1'b1;
        i_cfg_data  <= qlen;
        @(negedge i_clk);
        while (!o_cfg_ready) begin
            @(posedge i_clk);
            @(negedge i_clk);
        end
        @(posedge i_clk);
        cur_qlen = qlen;
        i_cfg_valid <= 1'b0;
        @(posedge i_clk);
    endtask

    task automatic restart_doc_tracking();
        int unsigned r;
        r = $urandom_range(0, 99);
        if (r < 15) cursor = longint'(POS_TOP) - $urandom_range(0, 3000);
        else if (r < 30) cursor = $urandom_range(0, 10);
        else cursor = $urandom;
        if (cursor > POS_TOP) cursor = POS_TOP;
        foreach (gen_seen[i]) begin
            gen_seen[i] = 1'b0;
            gen_last[i] = 0;
        end
    endtask

    // one document: mostly hits that steer toward coverage and window-start moves
    task automatic run_document(int unsigned n);
        int unsigned len;
        int unsigned r;
        int unsigned t;
        int unsigned k;
        logic        cmd;
        longint      pos;
        longint      lo;
        if ($urandom_range(0, 9) != 0) begin
            send_beat(CMD_NEW_DOC, 5'($urandom), $urandom, 1'b0, NO_COVER);
            counted++;
            restart_doc_tracking();
        end
        len = (n == 0) ? $urandom_range(2, 6) : n * $urandom_range(1, 3) + $urandom_range(0, 6);
        repeat (len) begin
            r = $urandom_range(0, 99);
            cmd = CMD_HIT;
            if (r < 8) begin
                // noise: any term, occasionally a stray new-document beat
                if ($urandom_range(0, 15) == 0) cmd = CMD_NEW_DOC;
                t = $urandom_range(0, TERMS - 1);
                pos = gen_seen[t] ? gen_last[t] + $urandom_range(0, 50) : longint'($urandom);
            end else if (n == 0 || (r < 13 && n < TERMS)) begin
                t = $urandom_range(n, TERMS - 1);
                pos = cursor;
            end else begin
                t = $urandom_range(0, n - 1);
                case ($urandom_range(0, 2))
                    0: begin
                        for (k = 0; k < n && gen_seen[t]; k++) t = (t + 1) % n;
                    end
                    1: begin
                        lo = -1;
                        for (k = 0; k < n; k++)
                            if (gen_seen[k] && (lo < 0 || gen_last[k] < lo)) begin
                                lo = gen_last[k];
                                t = k;
                            end
                    end
                    default: ;
                endcase
                r = $urandom_range(0, 99);
                if (r < 70) cursor += $urandom_range(0, 3);
                else if (r < 95) cursor += $urandom_range(4, 100);
                else cursor += $urandom_range(0, 1 << 24);
                if (cursor > POS_TOP) cursor = POS_TOP;
                pos = cursor;
                // a late first hit that lands behind the others
                if (!gen_seen[t] && $urandom_range(0, 9) == 0)
                    pos = longint'($urandom) % (cursor + 1);
            end
            if (gen_seen[t] && pos < gen_last[t]) pos = gen_last[t];
            if (pos > POS_TOP) pos = POS_TOP;
            send_beat(cmd, TERM_W'(t), pos[31:0], 1'b0, NO_COVER);
            if (cmd == CMD_NEW_DOC) begin
                counted++;
                restart_doc_tracking();
            end else begin
                if (t < n) counted++;
                gen_seen[t] = 1'b1;
                gen_last[t] = pos;
            end
        end
    endtask

    t_dir_row dir_tab [24] = '{
        '{6'd2,  CMD_NEW_DOC, 5'd0,  32'd0,         1'b1, NO_COVER},
        '{6'd2,  CMD_HIT,     5'd0,  32'd0,         1'b1, NO_COVER},
        // out-of-range terms leave the state alone
        '{6'd2,  CMD_HIT,     5'd5,  32'd7,         1'b1, NO_COVER},
        '{6'd2,  CMD_HIT,     5'd31, POS_TOP,       1'b1, NO_COVER},
        '{6'd2,  CMD_HIT,     5'd1,  POS_TOP,       1'b1,
          '{1'b1, 32'h0, 32'hFFFF_FFFF, POS_TOP}},
        '{6'd2,  CMD_HIT,     5'd0,  POS_TOP,       1'b1,
          '{1'b1, POS_TOP, 32'd1, POS_TOP}},
        '{6'd2,  CMD_NEW_DOC, 5'd0,  32'd0,         1'b1, NO_COVER},
        '{6'd2,  CMD_HIT,     5'd1,  32'd100,       1'b0, NO_COVER},
        '{6'd2,  CMD_HIT,     5'd0,  32'd40,        1'b0, NO_COVER},
        '{6'd2,  CMD_HIT,     5'd1,  32'd200,       1'b0, NO_COVER},
        '{6'd2,  CMD_HIT,     5'd0,  32'd150,       1'b0, NO_COVER},
        // zero query length: every hit ignored, even mid-document
        '{6'd0,  CMD_HIT,     5'd0,  32'd5,         1'b0, NO_COVER},
        '{6'd0,  CMD_NEW_DOC, 5'd3,  32'd9,         1'b1, NO_COVER},
        '{6'd0,  CMD_HIT,     5'd0,  32'd9,         1'b1, NO_COVER},
        // lengths above the lane count cap at all 32 terms
        '{6'd63, CMD_HIT,     5'd31, 32'd3,         1'b0, NO_COVER},
        '{6'd63, CMD_HIT,     5'd0,  32'd2,         1'b0, NO_COVER},
        // shrink mid-document: the seen bit of term 31 no longer counts
        '{6'd1,  CMD_HIT,     5'd0,  32'd10,        1'b0, NO_COVER},
        '{6'd1,  CMD_HIT,     5'd1,  32'd11,        1'b0, NO_COVER},
        '{6'd1,  CMD_NEW_DOC, 5'd0,  32'd0,         1'b1, NO_COVER},
        '{6'd1,  CMD_HIT,     5'd0,  32'h1234_5678, 1'b0, NO_COVER},
        '{6'd1,  CMD_HIT,     5'd0,  32'h8000_0000, 1'b0, NO_COVER},
        '{6'd1,  CMD_NEW_DOC, 5'd31, POS_TOP,       1'b1, NO_COVER},
        '{6'd32, CMD_HIT,     5'd31, 32'hA5A5_A5A5, 1'b0, NO_COVER},
        '{6'd32, CMD_HIT,     5'd0,  32'h5A5A_5A5A, 1'b0, NO_COVER}
    };

    logic [5:0] phase_qlen [15] = '{6'd1, 6'd32, 6'd2, 6'd0, 6'd63, 6'd3, 6'd33, 6'd5,
                                    6'd7, 6'd12, 6'd4, 6'd2, 6'd1, 6'd31, 6'd6};

    initial begin
        int unsigned phase;
        int unsigned quota;
        int unsigned n;
        int unsigned phase_start;
        logic [5:0]  qlen;
        foreach (term_pos[i]) term_pos[i] = '0;
        restart_doc_tracking();
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // grow the query one term at a time so every position entry is written
        // before any rescan can read it
        for (int k = 1; k <= TERMS; k++) begin
            settle_and_configure(6'(k));
            send_beat(CMD_HIT, TERM_W'(k - 1), 32'(k - 1), 1'b0, NO_COVER);
        end

        foreach (dir_tab[i]) begin
            if (dir_tab[i].qlen != cur_qlen) settle_and_configure(dir_tab[i].qlen);
            send_beat(dir_tab[i].cmd, dir_tab[i].term, dir_tab[i].pos,
                      dir_tab[i].typed, dir_tab[i].want);
        end

        phase = 0;
        counted = 0;
        while (counted < RAND_ITEMS) begin
            if (phase < 15) qlen = phase_qlen[phase];
            else if ($urandom_range(0, 9) == 0) qlen = 6'($urandom_range(0, 63));
            else qlen = 6'($urandom_range(1, 10));
            phase++;
            settle_and_configure(qlen);
            n = (qlen > TERMS) ? TERMS : qlen;
            quota = counted + ((n >= 16) ? 160 : 90);
            phase_start = counted;
            // a zero-length phase counts only new-document beats, keep it short
            while (counted < quota && !(n == 0 && counted - phase_start >= 4))
                run_document(n);
        end

        s_axis_tvalid <= 1'b0;
        do @(posedge i_clk); while (window_q.size() != 0);
        repeat (END_PAUSE) @(posedge i_clk);
        if (err_cnt == 0) begin
            $display("tb_min_window_all_terms_unit OK");
        end else begin
            $display("tb_min_window_all_terms_unit NOT OK");
        end
        $finish;
    end

endmodule
